// ----- src/lcdc_pkg.sv -----
// Package for the line CRC delayed check unit: beat types, codes and CRC function.
package lcdc_pkg;

    localparam int unsigned CRC_W  = 16;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] SEED_RESET = 16'hFFFF;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED   = 1'd1;

    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREV     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TWO_BACK = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              line_end;
        logic [CRC_W-1:0]  rx_crc;
    } t_in_beat;

    typedef struct packed {
        logic              crc_ok;
        logic [CRC_W-1:0]  line_crc;
    } t_out_beat;

    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_word(
        input logic [CRC_W-1:0]  crc,
        input logic [WORD_W-1:0] w
    );
        return crc_byte(crc_byte(crc, w[BYTE_W-1:0]), w[WORD_W-1:BYTE_W]);
    endfunction

endpackage

// ----- src/line_crc_delayed_check_unit.sv -----
// Line CRC16-CCITT unit with delayed compare against the line one or two back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in  (data_word, line_end, rx_crc)
//  out     | output    | o_out_valid/ i_out_stall| o_out (crc_ok, line_crc)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One beat per clock while o_in_stall is low; the input register takes the beat,
// then the two-byte CRC update is loaded into the result register.
// A beat without line_end produces no result and never waits on the output.
// A line_end beat holds in the input register while the result register is full
// and stalled; o_in_stall follows.
// Synchronous reset clears control state and history and sets the seed to 0xFFFF.
module line_crc_delayed_check_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  lcdc_pkg::t_in_beat                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output lcdc_pkg::t_out_beat                   o_out,
    input  logic                                  i_cfg_we,
    input  logic [lcdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lcdc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic                          r_in_valid, n_in_valid;
    lcdc_pkg::t_in_beat            r_in;
    logic                          r_out_valid, n_out_valid;
    lcdc_pkg::t_out_beat           r_out;
    logic [lcdc_pkg::MODE_W-1:0]   r_mode;
    logic [lcdc_pkg::CRC_W-1:0]    r_seed;
    logic [lcdc_pkg::CRC_W-1:0]    r_crc, n_crc;
    logic                          r_mid;
    logic [lcdc_pkg::CRC_W-1:0]    r_hist0, r_hist1;

    logic                          s1_fire;
    logic                          in_accept;
    logic                          end_fire;
    logic [lcdc_pkg::CRC_W-1:0]    expected;
    logic                          ok;

    assign s1_fire    = r_in_valid && (!r_in.line_end || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign end_fire   = s1_fire && r_in.line_end;

    assign n_crc    = lcdc_pkg::crc_word(r_mid ? r_crc : r_seed, r_in.data_word);
    assign expected = (r_mode == lcdc_pkg::MODE_PREV) ? r_hist0 : r_hist1;
    assign ok       = (r_mode == lcdc_pkg::MODE_NONE) || (r_in.rx_crc == expected);

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (s1_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (end_fire) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= lcdc_pkg::MODE_NONE;
            r_seed      <= lcdc_pkg::SEED_RESET;
            r_crc       <= lcdc_pkg::SEED_RESET;
            r_mid       <= 1'b0;
            r_hist0     <= '0;
            r_hist1     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lcdc_pkg::REG_CHECK_MODE: r_mode <= i_cfg_data[lcdc_pkg::MODE_W-1:0];
                    lcdc_pkg::REG_CRC_SEED:   r_seed <= i_cfg_data[lcdc_pkg::CRC_W-1:0];
                    default: ;
                endcase
            end
            if (s1_fire) begin
                r_crc <= n_crc;
                r_mid <= !r_in.line_end;
            end
            if (end_fire && (r_mode != lcdc_pkg::MODE_NONE)) begin
                r_hist1 <= r_hist0;
                r_hist0 <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (end_fire) begin
            r_out.crc_ok   <= ok;
            r_out.line_crc <= n_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_fire |=> o_out_valid)
        else $error("line end beat did not produce a result");

    a_mid_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_in.line_end) |=> r_mid)
        else $error("mid-line flag not set after a line word");

    a_hist_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (end_fire && (r_mode != lcdc_pkg::MODE_NONE)) |=> (r_hist0 == o_out.line_crc))
        else $error("history entry differs from reported line CRC");

    a_mode_none_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (end_fire && (r_mode == lcdc_pkg::MODE_NONE)) |=> ($stable(r_hist0) && $stable(r_hist1)))
        else $error("history shifted with checking off");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid) |-> !o_in_stall)
        else $error("input stalled with empty input register");
`endif

endmodule

// ----- verif/line_crc_delayed_check_unit_tb.sv -----
// Self-checking testbench for the line CRC delayed check unit: directed and random lines.
module line_crc_delayed_check_unit_tb;

    import lcdc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_TWO_BACK_ALIAS = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RANDOM_WORDS = 635;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [MODE_W-1:0] mode_q;
    logic [CRC_W-1:0]  seed_q;
    logic [CRC_W-1:0]  run_crc;
    logic [CRC_W-1:0]  crc_hist [2];
    logic              in_line;

    t_out_beat   line_results_q [$];
    t_out_beat   want;
    bit          in_idle;
    bit          out_idle;
    int unsigned err_cnt;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned bad_lines_seen;

    line_crc_delayed_check_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc16_word(
        input logic [CRC_W-1:0]  crc_in,
        input logic [WORD_W-1:0] w
    );
        logic [CRC_W-1:0]  c;
        logic [WORD_W-1:0] bit_order;
        logic              fb;
        c = crc_in;
        bit_order = {w[BYTE_W-1:0], w[WORD_W-1:BYTE_W]};
        for (int k = WORD_W - 1; k >= 0; k--) begin
            fb = c[CRC_W-1] ^ bit_order[k];
            c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] delayed_crc();
        return (mode_q == MODE_PREV) ? crc_hist[0] : crc_hist[1];
    endfunction

    function automatic t_in_beat beat(
        input logic [WORD_W-1:0] w,
        input logic              last,
        input logic [CRC_W-1:0]  rx
    );
        t_in_beat b;
        b.data_word = w;
        b.line_end  = last;
        b.rx_crc    = rx;
        return b;
    endfunction

    function automatic int unsigned draw_gap(input bit busy);
        return busy ? $urandom_range(0, 19) : 0;
    endfunction

    task automatic track_line_crc(input t_in_beat b);
        logic [CRC_W-1:0] crc;
        t_out_beat        r;
        crc = crc16_word(in_line ? run_crc : seed_q, b.data_word);
        run_crc = crc;
        if (!b.line_end) begin
            in_line = 1'b1;
        end else begin
            in_line = 1'b0;
            r.line_crc = crc;
            if (mode_q == MODE_NONE) begin
                r.crc_ok = 1'b1;
            end else begin
                r.crc_ok = (b.rx_crc == delayed_crc());
                crc_hist[1] = crc_hist[0];
                crc_hist[0] = crc;
            end
            line_results_q.push_back(r);
        end
    endtask

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = draw_gap(in_idle);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        track_line_crc(b);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_CHECK_MODE) begin
            mode_q = data[MODE_W-1:0];
        end else begin
            seed_q = data[CRC_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (!o_out.crc_ok) begin
                bad_lines_seen++;
            end
            if (line_results_q.size() == 0) begin
                $error("unexpected result beat: crc_ok %0d line_crc 0x%04h",
                       o_out.crc_ok, o_out.line_crc);
                err_cnt++;
            end else begin
                want = line_results_q.pop_front();
                if (o_out.crc_ok !== want.crc_ok) begin
                    $error("crc_ok mismatch: expected %0d, actual %0d",
                           want.crc_ok, o_out.crc_ok);
                    err_cnt++;
                end
                if (o_out.line_crc !== want.line_crc) begin
                    $error("line_crc mismatch: expected 0x%04h, actual 0x%04h",
                           want.line_crc, o_out.line_crc);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int unsigned hold;
        i_out_stall = 1'b0;
        forever begin
            hold = draw_gap(out_idle);
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic test_mode_none_after_reset();
        send_beat(beat(16'h0000, 1'b1, 16'hFFFF));
        send_beat(beat(16'hFFFF, 1'b0, 16'h0000));
        send_beat(beat(16'hFFFF, 1'b1, 16'h0000));
    endtask

    task automatic test_prev_line_compare();
        drain();
        write_reg(REG_CHECK_MODE, 16'hFFFC | CFG_DATA_W'(MODE_PREV));
        send_beat(beat(16'h1234, 1'b1, 16'h0000));
        send_beat(beat(16'hA55A, 1'b1, delayed_crc()));
        send_beat(beat(16'h8001, 1'b1, ~delayed_crc()));
    endtask

    task automatic test_two_back_compare();
        drain();
        write_reg(REG_CHECK_MODE, CFG_DATA_W'(MODE_TWO_BACK));
        send_beat(beat(16'h7FFE, 1'b1, delayed_crc()));
        send_beat(beat(16'h0001, 1'b1, ~delayed_crc()));
        send_beat(beat(16'hC3C3, 1'b1, delayed_crc()));
        drain();
        write_reg(REG_CHECK_MODE, CFG_DATA_W'(MODE_TWO_BACK_ALIAS));
        send_beat(beat(16'h3C3C, 1'b1, delayed_crc()));
        send_beat(beat(16'hFFFF, 1'b1, delayed_crc() ^ 16'h8000));
    endtask

    task automatic test_seed_writes();
        drain();
        write_reg(REG_CRC_SEED, 16'h0000);
        send_beat(beat(16'h0000, 1'b1, delayed_crc()));
        send_beat(beat(16'h00FF, 1'b0, 16'hFFFF));
        drain();
        write_reg(REG_CRC_SEED, 16'h1D0F);
        send_beat(beat(16'hFF00, 1'b1, delayed_crc()));
        send_beat(beat(16'h5AA5, 1'b1, delayed_crc()));
        drain();
        write_reg(REG_CHECK_MODE, CFG_DATA_W'(MODE_NONE));
        write_reg(REG_CRC_SEED, 16'hFFFF);
        send_beat(beat(16'h1111, 1'b1, 16'h2222));
        drain();
        write_reg(REG_CHECK_MODE, CFG_DATA_W'(MODE_PREV));
        send_beat(beat(16'h2222, 1'b1, delayed_crc()));
    endtask

    task automatic send_random_line(input int unsigned len);
        t_in_beat b;
        for (int unsigned k = 1; k <= len; k++) begin
            b.data_word = WORD_W'($urandom_range(0, 16'hFFFF));
            b.line_end  = (k == len);
            if (b.line_end && $urandom_range(0, 3) != 0) begin
                b.rx_crc = delayed_crc();
            end else begin
                b.rx_crc = CRC_W'($urandom_range(0, 16'hFFFF));
            end
            if (!b.line_end && $urandom_range(0, 39) == 0) begin
                drain();
                write_reg(REG_CRC_SEED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            end
            send_beat(b);
        end
    endtask

    task automatic test_random_lines(input int unsigned target);
        int unsigned first;
        int unsigned lines;
        int unsigned len;
        logic [CRC_W-1:0] s;
        first = words_sent;
        while (words_sent - first < target) begin
            drain();
            write_reg(REG_CHECK_MODE, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            case ($urandom_range(0, 3))
                0: s = '0;
                1: s = '1;
                default: s = CRC_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(REG_CRC_SEED, s);
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            lines = $urandom_range(3, 10);
            repeat (lines) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                send_random_line(len);
            end
        end
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        in_idle     = 1'b1;
        out_idle    = 1'b1;
        mode_q      = MODE_NONE;
        seed_q      = SEED_RESET;
        run_crc     = SEED_RESET;
        crc_hist[0] = '0;
        crc_hist[1] = '0;
        in_line     = 1'b0;
        err_cnt        = 0;
        words_sent     = 0;
        results_seen   = 0;
        bad_lines_seen = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_mode_none_after_reset();
        test_prev_line_compare();
        test_two_back_compare();
        test_seed_writes();
        test_random_lines(RANDOM_WORDS);
        drain();

        $display("covered %0d line words, %0d line results (%0d flagged as CRC mismatch)",
                 words_sent, results_seen, bad_lines_seen);
        $display("modes none/previous/two back/alias, extreme and random seeds, mid-line seed writes");
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/lcdc_pkg.sv
src/line_crc_delayed_check_unit.sv
verif/line_crc_delayed_check_unit_tb.sv
